@@ sv/rar_pkg.sv @@
package rar_pkg;

  localparam int unsigned DefWidth = 32;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GCD_START,
    S_GCD_MOD,
    S_GCD_STEP,
    S_DIV_MAG,
    S_DIV_DEN,
    S_NEXT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_COMBINE,
    S_CHECK,
    S_OUT
  } state_t;

  // request and reply between sequencer and the shared divider
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

@@ sv/rar_div.sv @@
module rar_div (
  input  logic              clk,
  input  logic              rst,
  input  rar_pkg::div_req_t req,
  output rar_pkg::div_rsp_t rsp
);

  logic [63:0] quot;
  logic [63:0] rem;
  logic [63:0] dvs;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem[62:0], quot[63]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
        quot <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (trial[64]) begin
          rem  <= rem_sh;
          quot <= {quot[62:0], 1'b0};
        end else begin
          rem  <= trial[63:0];
          quot <= {quot[62:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule

@@ sv/rar_ctrl.sv @@
module rar_ctrl #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_go,
  input  logic [1:0]        kind,
  input  logic [WIDTH-1:0]  an,
  input  logic [WIDTH-1:0]  ad,
  input  logic [WIDTH-1:0]  bn,
  input  logic [WIDTH-1:0]  bd,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       res_num,
  output logic [30:0]       res_den,
  output logic [1:0]        status,
  output rar_pkg::div_req_t dreq,
  input  rar_pkg::div_rsp_t drsp
);

  localparam logic [63:0] Lim = (64'd1 << (WIDTH - 1)) - 64'd1;

  rar_pkg::state_t state, state_next;

  // phase 0: operand a, 1: operand b, 2: result
  logic [1:0]  phase;
  logic [1:0]  kind_r;
  logic        a_neg, b_neg, r_neg;
  logic [63:0] a_mag, a_den, b_mag, b_den, r_mag, r_den;
  logic [63:0] gx, gy, g;
  logic [63:0] t1, t2;
  logic [63:0] mul_a, mul_b, mul_p;
  logic        an_s, ad_s, bn_s, bd_s;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic        s2;
  logic        ovf;

  assign an_s = an[WIDTH-1];
  assign ad_s = ad[WIDTH-1];
  assign bn_s = bn[WIDTH-1];
  assign bd_s = bd[WIDTH-1];
  assign an_m = an_s ? (~an + 1'b1) : an;
  assign ad_m = ad_s ? (~ad + 1'b1) : ad;
  assign bn_m = bn_s ? (~bn + 1'b1) : bn;
  assign bd_m = bd_s ? (~bd + 1'b1) : bd;

  // single 32x32 multiplier shared over three steps
  assign mul_p = {32'd0, mul_a[31:0]} * {32'd0, mul_b[31:0]};
  assign s2 = (kind_r == rar_pkg::KIND_SUB) ? !b_neg : b_neg;
  assign ovf = (r_den > Lim) || (r_neg ? (r_mag > Lim + 64'd1) : (r_mag > Lim));

  always_comb begin
    mul_a = a_mag;
    mul_b = b_den;
    case (state)
      rar_pkg::S_MUL1: begin
        if (kind_r == rar_pkg::KIND_MUL) begin
          mul_a = a_mag; mul_b = b_mag;
        end else begin
          mul_a = a_mag; mul_b = b_den;
        end
      end
      rar_pkg::S_MUL2: begin
        if (kind_r == rar_pkg::KIND_DIV) begin
          mul_a = b_mag; mul_b = a_den;
        end else if (kind_r == rar_pkg::KIND_MUL) begin
          mul_a = a_den; mul_b = b_den;
        end else begin
          mul_a = b_mag; mul_b = a_den;
        end
      end
      rar_pkg::S_MUL3: begin
        mul_a = a_den; mul_b = b_den;
      end
      default: begin
        mul_a = a_mag; mul_b = b_den;
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    dreq.start    = 1'b0;
    dreq.dividend = gx;
    dreq.divisor  = gy;
    case (state)
      rar_pkg::S_IDLE:
        if (in_go) state_next = rar_pkg::S_GCD_START;
      rar_pkg::S_GCD_START: begin
        // error items carry zeroed fields straight out
        if (status != rar_pkg::ST_OK) state_next = rar_pkg::S_OUT;
        else if (gx == 64'd0 || gy == 64'd0) state_next = rar_pkg::S_NEXT;
        else state_next = rar_pkg::S_GCD_MOD;
      end
      rar_pkg::S_GCD_MOD: begin
        if (gy == 64'd0) begin
          state_next    = rar_pkg::S_DIV_MAG;
          dreq.start    = 1'b1;
          dreq.dividend = (phase == 2'd0) ? a_mag : (phase == 2'd1) ? b_mag : r_mag;
          dreq.divisor  = gx;
        end else begin
          dreq.start = 1'b1;
          state_next = rar_pkg::S_GCD_STEP;
        end
      end
      rar_pkg::S_GCD_STEP:
        if (drsp.done) state_next = rar_pkg::S_GCD_MOD;
      rar_pkg::S_DIV_MAG:
        if (drsp.done) begin
          state_next    = rar_pkg::S_DIV_DEN;
          dreq.start    = 1'b1;
          dreq.dividend = (phase == 2'd0) ? a_den : (phase == 2'd1) ? b_den : r_den;
          dreq.divisor  = g;
        end
      rar_pkg::S_DIV_DEN:
        if (drsp.done) state_next = rar_pkg::S_NEXT;
      rar_pkg::S_NEXT: begin
        if (phase == 2'd0) state_next = rar_pkg::S_GCD_START;
        else if (phase == 2'd1) begin
          if (kind_r == rar_pkg::KIND_DIV && b_mag == 64'd0) state_next = rar_pkg::S_OUT;
          else state_next = rar_pkg::S_MUL1;
        end else state_next = rar_pkg::S_CHECK;
      end
      rar_pkg::S_MUL1: state_next = rar_pkg::S_MUL2;
      rar_pkg::S_MUL2: state_next = rar_pkg::S_MUL3;
      rar_pkg::S_MUL3: state_next = rar_pkg::S_COMBINE;
      rar_pkg::S_COMBINE: state_next = rar_pkg::S_GCD_START;
      rar_pkg::S_CHECK: state_next = rar_pkg::S_OUT;
      rar_pkg::S_OUT:
        if (out_ready) state_next = rar_pkg::S_IDLE;
      default: state_next = rar_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rar_pkg::S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      rar_pkg::S_IDLE:
        if (in_go) begin
          kind_r <= kind;
          phase  <= 2'd0;
          a_neg  <= an_s != ad_s;
          b_neg  <= bn_s != bd_s;
          a_mag  <= 64'(an_m);
          a_den  <= 64'(ad_m);
          b_mag  <= 64'(bn_m);
          b_den  <= 64'(bd_m);
          gx     <= 64'(an_m);
          gy     <= 64'(ad_m);
          res_num <= '0;
          res_den <= '0;
          if (ad_m == '0 || bd_m == '0) status <= rar_pkg::ST_ZERODEN;
          else if (kind == rar_pkg::KIND_DIV && bn_m == '0) status <= rar_pkg::ST_DIVZERO;
          else status <= rar_pkg::ST_OK;
        end
      rar_pkg::S_GCD_MOD:
        if (gy == 64'd0) g <= gx;
      rar_pkg::S_GCD_STEP:
        if (drsp.done) begin
          gx <= gy;
          gy <= drsp.rem;
        end
      rar_pkg::S_DIV_MAG:
        if (drsp.done) begin
          case (phase)
            2'd0: a_mag <= drsp.quot;
            2'd1: b_mag <= drsp.quot;
            default: r_mag <= drsp.quot;
          endcase
        end
      rar_pkg::S_DIV_DEN:
        if (drsp.done) begin
          case (phase)
            2'd0: a_den <= drsp.quot;
            2'd1: b_den <= drsp.quot;
            default: r_den <= drsp.quot;
          endcase
        end
      rar_pkg::S_NEXT: begin
        // zero numerator reduces to 0/1 without sign
        case (phase)
          2'd0: if (a_mag == 64'd0) begin a_den <= 64'd1; a_neg <= 1'b0; end
          2'd1: if (b_mag == 64'd0) begin b_den <= 64'd1; b_neg <= 1'b0; end
          default: if (r_mag == 64'd0) begin r_den <= 64'd1; r_neg <= 1'b0; end
        endcase
        if (phase == 2'd0) begin
          phase <= 2'd1;
          gx    <= b_mag;
          gy    <= b_den;
        end else if (phase == 2'd1) begin
          phase <= 2'd2;
        end
      end
      rar_pkg::S_MUL1: t1 <= mul_p;
      rar_pkg::S_MUL2: t2 <= mul_p;
      rar_pkg::S_MUL3: r_den <= mul_p;
      rar_pkg::S_COMBINE: begin
        if (kind_r == rar_pkg::KIND_MUL || kind_r == rar_pkg::KIND_DIV) begin
          r_mag <= t1;
          r_neg <= a_neg != b_neg;
          gx    <= t1;
          if (kind_r == rar_pkg::KIND_DIV) begin
            r_den <= t2;
            gy    <= t2;
          end else begin
            gy    <= r_den;
          end
        end else begin
          gy <= r_den;
          if (a_neg == s2) begin
            r_mag <= t1 + t2; r_neg <= a_neg; gx <= t1 + t2;
          end else if (t1 >= t2) begin
            r_mag <= t1 - t2; r_neg <= a_neg; gx <= t1 - t2;
          end else begin
            r_mag <= t2 - t1; r_neg <= s2; gx <= t2 - t1;
          end
        end
      end
      rar_pkg::S_CHECK: begin
        if (ovf) begin
          status  <= rar_pkg::ST_OVF;
          res_num <= '0;
          res_den <= '0;
        end else begin
          res_num <= r_neg ? (32'd0 - r_mag[31:0]) : r_mag[31:0];
          res_den <= r_den[30:0];
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state != rar_pkg::S_IDLE);
  assign out_valid = (state == rar_pkg::S_OUT);

endmodule

@@ sv/rational_arith_reduce.sv @@
// run time is data dependent; each divider pass serially produces 64 quotient
// bits, with one pass per euclid step and two per reduction, and each item runs
// up to three gcd loops and three reductions
// error items (zero denominator, divide by zero) go from gcd start straight to output
// throughput: one item at a time, set by the single shared 64-bit serial divider
// reset: synchronous, active high; returns to idle with no result pending
module rational_arith_reduce #(
  parameter int unsigned WIDTH = rar_pkg::DefWidth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status
);

  rar_pkg::div_req_t dreq;
  rar_pkg::div_rsp_t drsp;
  logic busy;

  assign in_ready = !busy;

  rar_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_go     (in_valid && !busy),
    .kind      (kind),
    .an        (a_num[WIDTH-1:0]),
    .ad        (a_den[WIDTH-1:0]),
    .bn        (b_num[WIDTH-1:0]),
    .bd        (b_den[WIDTH-1:0]),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_num   (res_num),
    .res_den   (res_den),
    .status    (status),
    .dreq      (dreq),
    .drsp      (drsp)
  );

  rar_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

endmodule

@@ sv/rar_check.sv @@
module rar_check (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] res_num,
  input logic [30:0] res_den,
  input logic [1:0]  status
);

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rar_pkg::ST_OK |-> res_num == '0 && res_den == '0)
    else $error("error result not zeroed");

  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rar_pkg::ST_OK |-> res_den != '0)
    else $error("ok result has zero denominator");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(status))
    else $error("result dropped under stall");

endmodule

bind rational_arith_reduce rar_check u_rar_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .res_num   (res_num),
  .res_den   (res_den),
  .status    (status)
);
